// File: sv/prwc_pkg.sv
// Shared types and constants for the periodic release window counter.
package prwc_pkg;

  localparam int RECORD_BITS_DEF = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  typedef struct packed {
    logic [63:0] window_start_ns;
    logic [63:0] window_end_ns;
    logic [63:0] release_period_ns;
    logic [15:0] records_per_release;
    logic        last_domain;
  } in_word_t;

  typedef struct packed {
    logic [63:0] domain_release_cnt;
    logic [63:0] domain_records;
    logic [1:0]  domain_status;
    logic [63:0] total_releases;
    logic [63:0] total_records;
    logic [1:0]  batch_status;
    logic        batch_done;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic div_start;  // init divider for start / period
    logic div_end;    // init divider for end / period
    logic div_step;   // one restoring step
    logic save_first; // store ceil(start/period)
    logic save_stop;  // store ceil(end/period)
    logic mul_start;  // init multiplier
    logic mul_step;   // one multiply step
    logic finish;     // form result and update totals
  } prwc_cmd_t;

endpackage

// File: sv/prwc_datapath.sv
// Datapath: shared bit-serial divider and multiplier, totals, result register.
module prwc_datapath #(
  parameter int RECORD_BITS = prwc_pkg::RECORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prwc_pkg::in_word_t  in_word,
  input  prwc_pkg::prwc_cmd_t cmd,
  output prwc_pkg::out_word_t res
);

  // usable record bits: the input field is 16 bits wide
  localparam int RB_IN = (RECORD_BITS < 16) ? RECORD_BITS : 16;

  logic [63:0] start_r, end_r, period_r;
  logic [RECORD_BITS-1:0] rec_r;
  logic last_r;

  // restoring divider: rem 65 bits, quotient shifts in
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] first_r, stop_r;

  // shift-add multiplier of rel by rec, with overflow flag
  logic [63:0] macc_r, macc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [RECORD_BITS-1:0] mplier_r, mplier_nxt;
  logic        movf_r, movf_nxt;
  logic        mhi_r, mhi_nxt; // mcand shifted past bit 63

  logic [64:0] trial;
  logic [64:0] madd;
  logic [63:0] quo_ceil;
  logic        rem_nz;

  logic [63:0] tot_rel_r, tot_rec_r;
  logic [1:0]  sticky_r;
  prwc_pkg::out_word_t res_r;

  assign res = res_r;

  always_comb begin
    trial   = {rem_r[63:0], quo_r[63]} - {1'b0, period_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_start) begin
      rem_nxt = '0;
      quo_nxt = start_r;
    end else if (cmd.div_end) begin
      rem_nxt = '0;
      quo_nxt = end_r;
    end else if (cmd.div_step) begin
      if (!trial[64]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[63:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
  end

  assign rem_nz   = (rem_r != '0);
  assign quo_ceil = (rem_nz && quo_r != '1) ? quo_r + 64'd1 : quo_r;

  always_comb begin
    madd       = {1'b0, macc_r} + {1'b0, mcand_r};
    macc_nxt   = macc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    movf_nxt   = movf_r;
    mhi_nxt    = mhi_r;
    if (cmd.mul_start) begin
      macc_nxt   = '0;
      mcand_nxt  = stop_r - first_r;
      mplier_nxt = rec_r;
      movf_nxt   = 1'b0;
      mhi_nxt    = 1'b0;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) begin
        macc_nxt = madd[63:0];
        if (madd[64] || mhi_r) movf_nxt = 1'b1;
      end
      mhi_nxt    = mhi_r | mcand_r[63];
      mcand_nxt  = {mcand_r[62:0], 1'b0};
      mplier_nxt = mplier_r >> 1;
    end
  end

  logic        bad_order, bad_arg, bad_cnt;
  logic [63:0] d_rel, d_rec;
  logic [1:0]  d_st;
  logic [64:0] sum_rel, sum_rec;

  always_comb begin
    bad_order = start_r > end_r;
    bad_arg   = (period_r == '0) || (rec_r == '0);
    bad_cnt   = stop_r < first_r;
    d_rel = '0;
    d_rec = '0;
    d_st  = prwc_pkg::ST_OK;
    if (bad_order || bad_arg || bad_cnt) begin
      d_st = prwc_pkg::ST_INVALID;
    end else if (movf_r) begin
      d_st = prwc_pkg::ST_CAPACITY;
    end else begin
      d_rel = stop_r - first_r;
      d_rec = macc_r;
    end
    sum_rel = {1'b0, tot_rel_r} + {1'b0, d_rel};
    sum_rec = {1'b0, tot_rec_r} + {1'b0, d_rec};
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    macc_r   <= macc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    movf_r   <= movf_nxt;
    mhi_r    <= mhi_nxt;
    if (cmd.load) begin
      start_r  <= in_word.window_start_ns;
      end_r    <= in_word.window_end_ns;
      period_r <= in_word.release_period_ns;
      rec_r    <= RECORD_BITS'(in_word.records_per_release[RB_IN-1:0]);
      last_r   <= in_word.last_domain;
    end
    if (cmd.save_first) first_r <= quo_ceil;
    if (cmd.save_stop)  stop_r  <= quo_ceil;
  end

  always_ff @(posedge clk) begin
    logic [63:0] nrel, nrec;
    logic [1:0]  nst;
    nrel = tot_rel_r;
    nrec = tot_rec_r;
    nst  = sticky_r;
    if (!rst_n) begin
      tot_rel_r <= '0;
      tot_rec_r <= '0;
      sticky_r  <= prwc_pkg::ST_OK;
    end else if (cmd.finish) begin
      if (sticky_r == prwc_pkg::ST_OK) begin
        if (d_st != prwc_pkg::ST_OK) begin
          nst = bad_order ? prwc_pkg::ST_INVALID : prwc_pkg::ST_CAPACITY;
        end else if (sum_rel[64] || sum_rec[64]) begin
          nst = prwc_pkg::ST_CAPACITY;
        end else begin
          nrel = sum_rel[63:0];
          nrec = sum_rec[63:0];
        end
      end
      res_r.domain_release_cnt <= d_rel;
      res_r.domain_records     <= d_rec;
      res_r.domain_status      <= d_st;
      res_r.total_releases     <= nrel;
      res_r.total_records      <= nrec;
      res_r.batch_status       <= nst;
      res_r.batch_done         <= last_r;
      if (last_r) begin
        tot_rel_r <= '0;
        tot_rec_r <= '0;
        sticky_r  <= prwc_pkg::ST_OK;
      end else begin
        tot_rel_r <= nrel;
        tot_rec_r <= nrec;
        sticky_r  <= nst;
      end
    end
  end

endmodule

// File: sv/prwc_ctrl.sv
// Controller: sequences the two divisions, the multiply and the output handshake.
module prwc_ctrl #(
  parameter int RECORD_BITS = prwc_pkg::RECORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output prwc_pkg::prwc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVA  = 3'd1;
  localparam logic [2:0] S_DIVB  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam int CW = (RECORD_BITS > 64) ? $clog2(RECORD_BITS + 1) : 7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIVA;
          cnt_nxt   = '0;
        end
      end
      S_DIVA: begin
        if (cnt_r == '0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = CW'(1);
        end else if (cnt_r <= CW'(64)) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          cmd.save_first = 1'b1;
          cmd.div_end    = 1'b1;
          cnt_nxt   = CW'(1);
          state_nxt = S_DIVB;
        end
      end
      S_DIVB: begin
        if (cnt_r <= CW'(64)) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          cmd.save_stop = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          cmd.mul_start = 1'b1;
          cnt_nxt = CW'(1);
        end else if (cnt_r <= CW'(RECORD_BITS)) begin
          cmd.mul_step = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// File: sv/periodic_release_window_counter_unit.sv
// Top level of the periodic release window counter.
// Each word runs start/period, then end/period on the same divider, then the multiply.
// The single restoring divider (one bit a cycle) and the shift-add multiplier (one record
//   bit a cycle) limit throughput; no new word is taken until the last one has finished.
// The next input word is taken while a finished result still waits on out_stall.
// Reset (rst_n low, synchronous): totals and batch status cleared, no result held.
module periodic_release_window_counter_unit #(
  parameter int RECORD_BITS = prwc_pkg::RECORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  prwc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prwc_pkg::out_word_t out_data
);

  // command bundle from the sequencer to the arithmetic
  prwc_pkg::prwc_cmd_t cmd;

  prwc_ctrl #(.RECORD_BITS(RECORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // divider, multiplier, running totals and the result register
  prwc_datapath #(.RECORD_BITS(RECORD_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_data),
    .cmd     (cmd),
    .res     (out_data)
  );

endmodule

// File: tb/periodic_release_window_counter_unit_tb.sv
// Testbench for the periodic release window counter: directed and random domain words.
module periodic_release_window_counter_unit_tb;

  localparam int RECORD_BITS = prwc_pkg::RECORD_BITS_DEF;
  localparam int LATENCY     = 2 * 65 + RECORD_BITS + 4;
  localparam int N_RANDOM    = 1230;
  // Idle limit: one full latency plus the long receiver hold-off, several times over.
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 800;

  // Window counter predictor: mirrors the batch totals and sticky status.
  class window_scoreboard;
    logic [63:0]         release_sum;
    logic [63:0]         record_sum;
    logic [1:0]          batch_state;
    prwc_pkg::out_word_t pending_q[$];
    int                  errors;
    int                  checked;
    int                  batches;
    int                  bad_domains;

    function new();
      release_sum = '0;
      record_sum  = '0;
      batch_state = prwc_pkg::ST_OK;
      errors      = 0;
      checked     = 0;
      batches     = 0;
      bad_domains = 0;
    endfunction

    function logic [63:0] div_round_up(logic [63:0] v, logic [63:0] d);
      logic [63:0] q;
      q = v / d;
      if ((v % d) != 0 && q != '1) q = q + 1;
      return q;
    endfunction

    function void note_word(prwc_pkg::in_word_t w);
      prwc_pkg::out_word_t r;
      logic [63:0] rec, first_cnt, stop_cnt, rel;
      logic [127:0] prod;
      rec = 64'(w.records_per_release[RECORD_BITS-1:0]);
      r = '0;
      r.domain_status = prwc_pkg::ST_OK;
      if (w.window_start_ns > w.window_end_ns) begin
        r.domain_status = prwc_pkg::ST_INVALID;
      end else if (w.release_period_ns == 0 || rec == 0) begin
        r.domain_status = prwc_pkg::ST_INVALID;
      end else begin
        first_cnt = div_round_up(w.window_start_ns, w.release_period_ns);
        stop_cnt  = div_round_up(w.window_end_ns, w.release_period_ns);
        if (stop_cnt < first_cnt) begin
          r.domain_status = prwc_pkg::ST_INVALID;
        end else begin
          rel  = stop_cnt - first_cnt;
          prod = rel * rec;
          if (prod[127:64] != 0) begin
            r.domain_status = prwc_pkg::ST_CAPACITY;
          end else begin
            r.domain_release_cnt = rel;
            r.domain_records     = prod[63:0];
          end
        end
      end
      if (r.domain_status != prwc_pkg::ST_OK) bad_domains++;
      // first error wins; totals freeze until batch close
      if (batch_state == prwc_pkg::ST_OK) begin
        if (r.domain_status != prwc_pkg::ST_OK) begin
          batch_state = (w.window_start_ns > w.window_end_ns) ? prwc_pkg::ST_INVALID
                                                              : prwc_pkg::ST_CAPACITY;
        end else if (release_sum > ~r.domain_release_cnt ||
                     record_sum > ~r.domain_records) begin
          batch_state = prwc_pkg::ST_CAPACITY;
        end else begin
          release_sum = release_sum + r.domain_release_cnt;
          record_sum  = record_sum + r.domain_records;
        end
      end
      r.total_releases = release_sum;
      r.total_records  = record_sum;
      r.batch_status   = batch_state;
      r.batch_done     = w.last_domain;
      if (w.last_domain) begin
        release_sum = '0;
        record_sum  = '0;
        batch_state = prwc_pkg::ST_OK;
        batches++;
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_word(prwc_pkg::out_word_t got);
      prwc_pkg::out_word_t exp_w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      checked++;
      if (got.domain_release_cnt !== exp_w.domain_release_cnt)
        $display("%0t: domain_release_cnt exp %h got %h", $time,
                 exp_w.domain_release_cnt, got.domain_release_cnt);
      if (got.domain_records !== exp_w.domain_records)
        $display("%0t: domain_records exp %h got %h", $time,
                 exp_w.domain_records, got.domain_records);
      if (got.domain_status !== exp_w.domain_status)
        $display("%0t: domain_status exp %0d got %0d", $time,
                 exp_w.domain_status, got.domain_status);
      if (got.total_releases !== exp_w.total_releases)
        $display("%0t: total_releases exp %h got %h", $time,
                 exp_w.total_releases, got.total_releases);
      if (got.total_records !== exp_w.total_records)
        $display("%0t: total_records exp %h got %h", $time,
                 exp_w.total_records, got.total_records);
      if (got.batch_status !== exp_w.batch_status)
        $display("%0t: batch_status exp %0d got %0d", $time,
                 exp_w.batch_status, got.batch_status);
      if (got.batch_done !== exp_w.batch_done)
        $display("%0t: batch_done exp %0d got %0d", $time,
                 exp_w.batch_done, got.batch_done);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  prwc_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  prwc_pkg::out_word_t out_data;

  window_scoreboard sb = new();
  bit   sender_done = 1'b0;
  bit   hold_req = 1'b0;    // sender asks receiver for the long hold-off
  bit   no_idle = 1'b0;     // stretch with no idling on either side
  int   idle_cycles = 0;

  always #10 clk = ~clk;

  periodic_release_window_counter_unit #(.RECORD_BITS(RECORD_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Result side: sample at the edge, check accepted words, note progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_word(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall: random about 14% of cycles, plus one long hold-off.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= (!no_idle && $urandom_range(99) < 14);
        @(posedge clk);
      end
    end
  end

  // Present one word and hold it until the block takes it; valid stays up
  // after the accept so a back-to-back word needs no second assignment.
  task automatic send_word(prwc_pkg::in_word_t w);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly realistic windows: start is a shared cursor, end a bit later,
  // small periods; a slice of wide random values hits overflow and errors.
  function automatic prwc_pkg::in_word_t rand_word(logic [63:0] cursor, bit last);
    prwc_pkg::in_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.window_start_ns   = cursor;
    w.window_end_ns     = cursor + 64'($urandom_range(100000));
    w.release_period_ns = 64'($urandom_range(5000, 1));
    w.records_per_release = 16'($urandom_range(65535, 1));
    w.last_domain = last;
    if (pick < 5) w.window_end_ns = cursor - 64'($urandom_range(1000, 1));
    else if (pick < 8) w.release_period_ns = '0;
    else if (pick < 11) w.records_per_release = '0;
    else if (pick < 16) begin
      // big windows, tiny periods: multiply and total overflow
      w.window_start_ns   = 64'($urandom_range(100));
      w.window_end_ns     = rand64() | 64'h8000_0000_0000_0000;
      w.release_period_ns = 64'($urandom_range(3, 1));
    end else if (pick < 22) begin
      w.window_start_ns   = rand64();
      w.window_end_ns     = rand64();
      w.release_period_ns = rand64() >> $urandom_range(63);
      w.records_per_release = 16'($urandom);
    end
    return w;
  endfunction

  task automatic run_directed();
    prwc_pkg::in_word_t w;
    logic [63:0] mx;
    mx = '1;
    // plain batch of two
    w = '{64'd1000, 64'd5000, 64'd300, 16'd7, 1'b0}; send_word(w);
    w = '{64'd1000, 64'd1000, 64'd1, 16'hFFFF, 1'b1}; send_word(w);
    // start after end, then more items frozen
    w = '{64'd10, 64'd9, 64'd1, 16'd1, 1'b0}; send_word(w);
    w = '{64'd0, 64'd100, 64'd10, 16'd2, 1'b1}; send_word(w);
    // zero period, zero records
    w = '{64'd0, 64'd100, 64'd0, 16'd2, 1'b1}; send_word(w);
    w = '{64'd0, 64'd100, 64'd10, 16'd0, 1'b1}; send_word(w);
    // max end, period 1: multiply overflow
    w = '{64'd0, mx, 64'd1, 16'hFFFF, 1'b1}; send_word(w);
    w = '{64'd0, mx, 64'd1, 16'd1, 1'b0}; send_word(w);
    // total overflow on the second domain
    w = '{64'd0, mx, 64'd1, 16'd1, 1'b1}; send_word(w);
    // start and end both at max, max period
    w = '{mx, mx, mx, 16'd1, 1'b1}; send_word(w);
    w = '{64'd1, mx, mx, 16'hFFFF, 1'b1}; send_word(w);
    w = '{mx - 1, mx, 64'd2, 16'h8000, 1'b1}; send_word(w);
    w = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h3, 16'h5555, 1'b1};
    send_word(w);
    // multiply error after an invalid start keeps invalid batch status
    w = '{64'd5, 64'd4, 64'd1, 16'd1, 1'b0}; send_word(w);
    w = '{64'd0, mx, 64'd1, 16'hFFFF, 1'b1}; send_word(w);
  endtask

  task automatic run_random();
    logic [63:0] cursor;
    int left, i;
    cursor = rand64() >> $urandom_range(63);
    left = $urandom_range(6, 1);
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 200) no_idle = 1'b1;
      if (i == 350) no_idle = 1'b0;
      if (i == 500) hold_req = 1'b1;  // sender keeps offering meanwhile
      left--;
      send_word(rand_word(cursor, left == 0 || i == N_RANDOM - 1));
      if (left == 0) begin
        cursor = ($urandom_range(3) == 0) ? rand64() : cursor + 64'($urandom_range(50000));
        left = $urandom_range(6, 1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // End of run and watchdog.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (sender_done && sb.pending_q.size() == 0) begin
        repeat (LATENCY + 20) @(posedge clk);
        $display("Checked %0d result words over %0d batches, %0d faulty domains.",
                 sb.checked, sb.batches, sb.bad_domains);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
          $display("CHECK OK");
        end else begin
          $display("CHECK FAILED");
        end
        $finish;
      end
    end
  end

endmodule

// File: periodic_release_window_counter_unit.f
sv/prwc_pkg.sv
sv/prwc_datapath.sv
sv/prwc_ctrl.sv
sv/periodic_release_window_counter_unit.sv
tb/periodic_release_window_counter_unit_tb.sv
